FILE: rtl/drbp_pkg.sv
// Shared types and constants for the dual rate bucket policer.
package drbp_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned LEVEL_W     = 40;
  localparam int unsigned LEAK_W      = 32;
  localparam int unsigned BURST_W     = 24;
  localparam int unsigned SLOT_W      = 32;
  localparam int unsigned BYTES_W     = 16;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned COLOR_W     = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [MODE_W-1:0] MODE_PASS_ALL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DROP_COMM  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DROP_PEAK  = 2'd3;

  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMMITTED_LEAK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMITTED_BURST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEAK       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_BURST      = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]  police_mode;
    logic [LEAK_W-1:0]  committed_leak_per_slot;
    logic [BURST_W-1:0] committed_burst;
    logic [LEAK_W-1:0]  peak_leak_per_slot;
    logic [BURST_W-1:0] peak_burst;
  } cfg_t;

endpackage

FILE: rtl/drbp_if.sv
// Valid/ready channel interfaces for arrival words and verdict words.
interface drbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] arrival_slot;
  logic [15:0] packet_bytes;

  modport source (output valid, output arrival_slot, output packet_bytes, input ready);
  modport sink   (input valid, input arrival_slot, input packet_bytes, output ready);
endinterface

interface drbp_out_if;
  logic       valid;
  logic       ready;
  logic       pass;
  logic [1:0] color;

  modport source (output valid, output pass, output color, input ready);
  modport sink   (input valid, input pass, input color, output ready);
endinterface

FILE: rtl/drbp_cfg.sv
// Configuration register file for the policer.
module drbp_cfg (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [drbp_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [drbp_pkg::CFG_DATA_W-1:0] wr_data,
  output drbp_pkg::cfg_t           cfg
);
  import drbp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_POLICE_MODE:     cfg.police_mode             <= wr_data[MODE_W-1:0];
        REG_COMMITTED_LEAK:  cfg.committed_leak_per_slot <= wr_data[LEAK_W-1:0];
        REG_COMMITTED_BURST: cfg.committed_burst         <= wr_data[BURST_W-1:0];
        REG_PEAK_LEAK:       cfg.peak_leak_per_slot      <= wr_data[LEAK_W-1:0];
        REG_PEAK_BURST:      cfg.peak_burst              <= wr_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/drbp_bucket.sv
// Leak-then-add update of one token bucket.
module drbp_bucket (
  input  logic [drbp_pkg::LEVEL_W-1:0] level,
  input  logic [drbp_pkg::LEAK_W-1:0]  leak,
  input  logic [drbp_pkg::BURST_W-1:0] burst,
  input  logic                         do_leak,
  input  logic [drbp_pkg::SLOT_W-2:0]  elapsed,
  input  logic [drbp_pkg::BYTES_W-1:0] bytes,
  output logic [drbp_pkg::LEVEL_W-1:0] level_next,
  output logic                         conform
);
  import drbp_pkg::*;

  localparam int unsigned DRAIN_W = SLOT_W - 1 + LEAK_W;

  logic [DRAIN_W-1:0] drain;
  logic [LEVEL_W-1:0] leaked;
  logic [LEVEL_W:0]   added;
  logic [LEVEL_W:0]   limit;

  always_comb begin
    drain = DRAIN_W'(elapsed) * DRAIN_W'(leak);
    if (!do_leak) begin
      leaked = level;
    end else if (drain >= DRAIN_W'(level)) begin
      leaked = '0;
    end else begin
      leaked = level - drain[LEVEL_W-1:0];
    end
    added   = {1'b0, leaked} + (LEVEL_W+1)'({bytes, {FRAC_BITS{1'b0}}});
    limit   = (LEVEL_W+1)'({burst, {FRAC_BITS{1'b0}}});
    conform = (added <= limit);
    level_next = conform ? added[LEVEL_W-1:0] : leaked;
  end
endmodule

FILE: rtl/dual_rate_bucket_policer_top.sv
// Top level of the dual rate bucket policer.
// Usage:
//   in_ch carries one arrival word per packet: arrival_slot and packet_bytes.
//   out_ch returns one verdict word per arrival, in order: pass and color.
//   wr_en/wr_index/wr_data write the mode, leaks and bursts; write only
//   while no arrival is in flight.
// Path: an accepted arrival lands in the input register, and its verdict
//   is registered in the verdict register once that register is free,
//   which raises out_ch.valid.
// Throughput: one arrival per cycle while out_ch.ready is high. Both
//   bucket updates, each one 31x32 multiply followed by a compare and
//   add, run combinationally between the input and verdict registers,
//   since each arrival reads the levels the previous one left.
// Reset: levels, last slot and all configuration clear to zero; no
//   words are held.
// Stall: when out_ch.ready is low the verdict holds, the input register
//   holds behind it, and in_ch.ready drops once both are full.
module dual_rate_bucket_policer_top (
  input  logic                             clk,
  input  logic                             rst,
  drbp_in_if.sink                          in_ch,
  drbp_out_if.source                       out_ch,
  input  logic                             wr_en,
  input  logic [drbp_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [drbp_pkg::CFG_DATA_W-1:0]  wr_data
);
  import drbp_pkg::*;

  cfg_t cfg;

  logic               in_valid;
  logic [SLOT_W-1:0]  in_slot;
  logic [BYTES_W-1:0] in_bytes;

  logic [LEVEL_W-1:0] committed_level;
  logic [LEVEL_W-1:0] peak_level;
  logic [SLOT_W-1:0]  previous_slot;

  logic [LEVEL_W-1:0] committed_level_next;
  logic [LEVEL_W-1:0] peak_level_next;
  logic               conf_c;
  logic               conf_p;

  logic [SLOT_W-1:0]  diff;
  logic               do_leak;
  logic               advance;
  logic               out_valid;
  logic               pass_next;
  logic [COLOR_W-1:0] color_next;

  drbp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  assign diff    = in_slot - previous_slot;
  assign do_leak = ~diff[SLOT_W-1];

  drbp_bucket u_committed (
    .level      (committed_level),
    .leak       (cfg.committed_leak_per_slot),
    .burst      (cfg.committed_burst),
    .do_leak    (do_leak),
    .elapsed    (diff[SLOT_W-2:0]),
    .bytes      (in_bytes),
    .level_next (committed_level_next),
    .conform    (conf_c)
  );

  drbp_bucket u_peak (
    .level      (peak_level),
    .leak       (cfg.peak_leak_per_slot),
    .burst      (cfg.peak_burst),
    .do_leak    (do_leak),
    .elapsed    (diff[SLOT_W-2:0]),
    .bytes      (in_bytes),
    .level_next (peak_level_next),
    .conform    (conf_p)
  );

  always_comb begin
    pass_next  = 1'b1;
    color_next = COLOR_GREEN;
    case (cfg.police_mode)
      MODE_MARK: begin
        if (!conf_p) begin
          color_next = COLOR_RED;
        end else if (!conf_c) begin
          color_next = COLOR_YELLOW;
        end else begin
          color_next = COLOR_GREEN;
        end
      end
      MODE_DROP_COMM: pass_next = conf_c;
      MODE_DROP_PEAK: pass_next = conf_p;
      default: ;
    endcase
  end

  assign advance     = in_valid & (~out_valid | out_ch.ready);
  assign in_ch.ready = ~in_valid | advance;
  assign out_ch.valid = out_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_slot  <= in_ch.arrival_slot;
      in_bytes <= in_ch.packet_bytes;
    end
  end

  // bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      committed_level <= '0;
      peak_level      <= '0;
      previous_slot   <= '0;
    end else if (advance) begin
      committed_level <= committed_level_next;
      peak_level      <= peak_level_next;
      previous_slot   <= in_slot;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.pass  <= pass_next;
      out_ch.color <= color_next;
    end
  end
endmodule
